// ===== hw/rtl/heat_equation_stencil_step_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef HEAT_EQUATION_STENCIL_STEP_TOP_MACROS_SVH
`define HEAT_EQUATION_STENCIL_STEP_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define HES_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hes check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define HES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hes check failed");

`endif

// ===== hw/rtl/hes_pkg.sv =====
package hes_pkg;

    localparam int unsigned VAL_W     = 32;
    localparam int unsigned COEF_W    = 16;
    localparam int unsigned IDX_OUT_W = 6;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED = 2'd2;

    // Reset values.
    localparam logic [COEF_W-1:0]       COEF_RESET  = 16'd328;
    localparam logic signed [VAL_W-1:0] INIT_RESET  = 32'sd6225920;
    localparam logic signed [VAL_W-1:0] FIXED_RESET = 32'sd4915200;

    // Coefficient of 0.5 in Q0.16; at or above it a step is refused.
    localparam logic [COEF_W-1:0] COEF_HALF = 16'd32768;

    localparam logic MODE_RESTART = 1'b0;
    localparam logic MODE_STEP    = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic signed [VAL_W-1:0] left_ghost;
        logic signed [VAL_W-1:0] right_ghost;
        logic signed [VAL_W-1:0] left_boundary_value;
        logic                    use_left_boundary;
        logic                    use_right_boundary;
    } in_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]    node_index;
        logic signed [VAL_W-1:0] node_value;
        logic                    last;
        logic                    stability_error;
    } out_t;

    typedef struct packed {
        logic load_init;
        logic calc;
        logic update;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/hes_cell.sv =====
module hes_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  hes_pkg::cell_ctrl_t              ctrl,
    input  logic [hes_pkg::COEF_W-1:0]       coef,
    input  logic signed [hes_pkg::VAL_W-1:0] left_val,
    input  logic signed [hes_pkg::VAL_W-1:0] right_val,
    input  logic signed [hes_pkg::VAL_W-1:0] shift_in,
    input  logic signed [hes_pkg::VAL_W-1:0] init_val,
    input  logic                             repl_en,
    input  logic signed [hes_pkg::VAL_W-1:0] repl_val,
    output logic signed [hes_pkg::VAL_W-1:0] h
);

    localparam int unsigned LAP_W  = hes_pkg::VAL_W + 2;
    localparam int unsigned PROD_W = LAP_W + hes_pkg::COEF_W + 1;
    localparam int unsigned TERM_W = PROD_W + 1 - 16;
    localparam int unsigned SUM_W  = TERM_W + 1;

    logic signed [hes_pkg::VAL_W-1:0] h_reg, h_next;
    logic signed [PROD_W-1:0]         prod_reg;
    logic signed [LAP_W-1:0]          lap;
    logic signed [PROD_W-1:0]         prod_next;
    logic signed [PROD_W:0]           rnd_sum;
    logic signed [TERM_W-1:0]         term;
    logic signed [SUM_W-1:0]          sum;
    logic signed [hes_pkg::VAL_W-1:0] sat_val;

    always_comb begin
        lap = LAP_W'(left_val) - (LAP_W'(h_reg) <<< 1) + LAP_W'(right_val);
        prod_next = PROD_W'($signed({1'b0, coef})) * PROD_W'(lap);
    end

    // Round to nearest, ties up: floor((p + 0.5) / 1.0), then saturate h + term.
    always_comb begin
        rnd_sum = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(32768);
        term    = rnd_sum[PROD_W:16];
        sum     = SUM_W'(h_reg) + SUM_W'(term);
        if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
            sat_val = 32'sh7FFF_FFFF;
        end else if (sum < SUM_W'(32'sh8000_0000)) begin
            sat_val = 32'sh8000_0000;
        end else begin
            sat_val = sum[hes_pkg::VAL_W-1:0];
        end
    end

    always_comb begin
        priority if (ctrl.load_init) begin
            h_next = init_val;
        end else if (ctrl.update) begin
            h_next = repl_en ? repl_val : sat_val;
        end else if (ctrl.shift) begin
            h_next = shift_in;
        end else begin
            h_next = h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg <= hes_pkg::INIT_RESET;
        end else begin
            h_reg <= h_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.calc) begin
            prod_reg <= prod_next;
        end
    end

    assign h = h_reg;

endmodule

// ===== hw/rtl/heat_equation_stencil_step_top.sv =====
// Sequence: a step word passes an update state before its first result word; a restart or
//   refused step goes straight to emit. The NODES result words then follow one per cycle while m_ready is high.
// A new input word is taken only once the last result word of the previous one is accepted,
//   as the cell chain rotates every node past the output, one per accepted result word.
// Reset (aresetn low, synchronous): every node back to 95.0, registers to their defaults,
//   control idle with no result word pending.
module heat_equation_stencil_step_top #(
    parameter int unsigned NODES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  hes_pkg::in_t                       s_data,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output hes_pkg::out_t                      m_data,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [hes_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hes_pkg::VAL_W-1:0]          cfg_wr_data
);

    localparam int unsigned IDX_W = $clog2(NODES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_EMIT
    } state_t;

    state_t                           state_reg;
    logic [IDX_W-1:0]                 idx_reg;
    logic                             err_reg;
    hes_pkg::in_t                     in_reg;

    logic [hes_pkg::COEF_W-1:0]       coef_reg;
    logic signed [hes_pkg::VAL_W-1:0] init_reg;
    logic signed [hes_pkg::VAL_W-1:0] fixed_reg;

    hes_pkg::cell_ctrl_t              ctrl;
    logic                             s_fire;
    logic                             m_fire;
    logic                             stable;
    logic                             idx_last;
    logic signed [hes_pkg::VAL_W-1:0] h_w [NODES];

    // ------------------------------------------------------------------
    // Configuration registers: the user must write them only while idle; the block does not enforce it.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg  <= hes_pkg::COEF_RESET;
            init_reg  <= hes_pkg::INIT_RESET;
            fixed_reg <= hes_pkg::FIXED_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hes_pkg::REG_COEF:  coef_reg  <= cfg_wr_data[hes_pkg::COEF_W-1:0];
                hes_pkg::REG_INIT:  init_reg  <= cfg_wr_data;
                hes_pkg::REG_FIXED: fixed_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshakes and cell control.
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = (state_reg == ST_EMIT);
    assign m_fire   = m_valid && m_ready;
    assign stable   = (coef_reg < hes_pkg::COEF_HALF);
    assign idx_last = (idx_reg == IDX_W'(NODES - 1));

    always_comb begin
        // Restart loads every cell at the accepting edge.
        ctrl.load_init = s_fire && (s_data.mode == hes_pkg::MODE_RESTART);
        // Stencil products are taken at the accepting edge, from the live ghosts.
        ctrl.calc      = s_fire && (s_data.mode == hes_pkg::MODE_STEP) && stable;
        // Add, round and saturate in the following cycle.
        ctrl.update    = (state_reg == ST_UPD);
        // Rotate the chain toward cell 0 on every accepted result word.
        ctrl.shift     = m_fire;
    end

    // ------------------------------------------------------------------
    // Sequencer: idle -> (update) -> emit NODES words -> idle.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            err_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        idx_reg <= '0;
                        if (s_data.mode == hes_pkg::MODE_RESTART) begin
                            err_reg   <= 1'b0;
                            state_reg <= ST_EMIT;
                        end else if (!stable) begin
                            // Refused step: hold the nodes, flag every word.
                            err_reg   <= 1'b1;
                            state_reg <= ST_EMIT;
                        end else begin
                            err_reg   <= 1'b0;
                            state_reg <= ST_UPD;
                        end
                    end
                end
                ST_UPD: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (m_fire) begin
                        if (idx_last) begin
                            idx_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Boundary controls are registered at acceptance for use in the update state.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. Cell i holds node i while idle; during emit it rotates.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < NODES; i++) begin : g_cell
        logic signed [hes_pkg::VAL_W-1:0] left_val;
        logic signed [hes_pkg::VAL_W-1:0] right_val;
        logic                             repl_en;
        logic signed [hes_pkg::VAL_W-1:0] repl_val;

        if (i == 0) begin : g_first
            assign left_val = s_data.left_ghost;
            assign repl_en  = in_reg.use_left_boundary;
            assign repl_val = in_reg.left_boundary_value;
        end else begin : g_inner_l
            assign left_val = h_w[i-1];
        end

        if (i == NODES - 1) begin : g_last
            assign right_val = s_data.right_ghost;
            assign repl_en   = in_reg.use_right_boundary;
            assign repl_val  = fixed_reg;
        end else begin : g_inner_r
            assign right_val = h_w[i+1];
        end

        if ((i != 0) && (i != NODES - 1)) begin : g_mid
            assign repl_en  = 1'b0;
            assign repl_val = '0;
        end

        hes_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .coef      (coef_reg),
            .left_val  (left_val),
            .right_val (right_val),
            .shift_in  (h_w[(i + 1) % NODES]),
            .init_val  (init_reg),
            .repl_en   (repl_en),
            .repl_val  (repl_val),
            .h         (h_w[i])
        );
    end

    // Result word comes straight from cell 0 and the sequencer registers.
    always_comb begin
        m_data.node_index      = hes_pkg::IDX_OUT_W'(idx_reg);
        m_data.node_value      = h_w[0];
        m_data.last            = idx_last;
        m_data.stability_error = err_reg;
    end

endmodule

// ===== hw/rtl/hes_checker.sv =====
`include "heat_equation_stencil_step_top_macros.svh"

module hes_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input hes_pkg::out_t m_data
);

    // A stalled result word holds.
    `HES_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // No input word is taken while results are still going out.
    `HES_ASSERT_NOW(a_no_overlap, aclk, aresetn, s_valid && s_ready, !m_valid)

    // The run closes after its last word.
    `HES_ASSERT_NEXT(a_run_end, aclk, aresetn, m_valid && m_ready && m_data.last, !m_valid)

    // Inside a run, indexes climb by one.
    `HES_ASSERT_NEXT(a_idx_step, aclk, aresetn, m_valid && m_ready && !m_data.last, m_valid && (m_data.node_index == 6'($past(m_data.node_index) + 6'd1)))

endmodule

bind heat_equation_stencil_step_top hes_checker u_hes_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import hes_pkg::*;

    localparam int unsigned NODES = 16;

    // Q16.16 landmarks used by the directed words.
    localparam logic signed [VAL_W-1:0] Q_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] Q_MIN      = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] Q_TEN      = 32'sd655360;
    localparam logic signed [VAL_W-1:0] Q_HUNDRED  = 32'sd6553600;
    localparam logic signed [VAL_W-1:0] Q_NEG_ONE  = -32'sd1;
    localparam logic signed [VAL_W-1:0] Q_HALF_LSB = 32'sd32768;

    // Index 3 decodes to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned RAND_PHASES   = 5;
    localparam int unsigned WORDS_PER_PHASE = 22;

    // Predicts the node values after every input word and holds the result
    // words still owed by the block, oldest first.
    class stencil_scoreboard;
        logic [COEF_W-1:0]       coef;
        logic signed [VAL_W-1:0] init_val;
        logic signed [VAL_W-1:0] fixed_val;
        logic signed [VAL_W-1:0] temps [NODES];
        out_t                    owed_words [$];
        int                      fail_count;
        int                      restarts;
        int                      steps_applied;
        int                      refusals;
        int                      words_checked;

        function new();
            coef          = COEF_RESET;
            init_val      = INIT_RESET;
            fixed_val     = FIXED_RESET;
            foreach (temps[i]) temps[i] = INIT_RESET;
            fail_count    = 0;
            restarts      = 0;
            steps_applied = 0;
            refusals      = 0;
            words_checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
            case (idx)
                REG_COEF:  coef      = data[COEF_W-1:0];
                REG_INIT:  init_val  = data;
                REG_FIXED: fixed_val = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        function void note_input(in_t w);
            logic signed [VAL_W-1:0] fresh [NODES];
            longint h;
            longint nb_l;
            longint nb_r;
            longint lap;
            longint term;
            longint sum;
            bit     refused;
            out_t   o;
            refused = 1'b0;
            if (w.mode == MODE_RESTART) begin
                foreach (temps[i]) temps[i] = init_val;
                restarts++;
            end else if (coef >= COEF_HALF) begin
                // unstable coefficient: nodes hold, boundary inputs ignored
                refused = 1'b1;
                refusals++;
            end else begin
                for (int i = 0; i < NODES; i++) begin
                    h = temps[i];
                    if (i == 0) nb_l = w.left_ghost;
                    else nb_l = temps[i-1];
                    if (i == NODES - 1) nb_r = w.right_ghost;
                    else nb_r = temps[i+1];
                    lap  = nb_l - 2 * h + nb_r;
                    // round to nearest, ties toward plus infinity
                    term = (longint'(coef) * lap + 32768) >>> 16;
                    sum  = h + term;
                    if (sum > longint'(Q_MAX)) sum = Q_MAX;
                    if (sum < longint'(Q_MIN)) sum = Q_MIN;
                    fresh[i] = sum[VAL_W-1:0];
                end
                if (w.use_left_boundary) fresh[0] = w.left_boundary_value;
                if (w.use_right_boundary) fresh[NODES-1] = fixed_val;
                foreach (temps[i]) temps[i] = fresh[i];
                steps_applied++;
            end
            for (int i = 0; i < NODES; i++) begin
                o.node_index      = i[IDX_OUT_W-1:0];
                o.node_value      = temps[i];
                o.last            = (i == NODES - 1);
                o.stability_error = refused;
                owed_words.push_back(o);
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (owed_words.size() == 0) begin
                $error("result word with nothing owed: index %0d value %0d",
                       got.node_index, got.node_value);
                fail_count++;
                return;
            end
            want = owed_words.pop_front();
            words_checked++;
            if (got.node_index !== want.node_index) begin
                $error("node_index expected %0d actual %0d", want.node_index, got.node_index);
                fail_count++;
            end
            if (got.node_value !== want.node_value) begin
                $error("node_value expected %0d actual %0d (node %0d)",
                       want.node_value, got.node_value, want.node_index);
                fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0b actual %0b", want.last, got.last);
                fail_count++;
            end
            if (got.stability_error !== want.stability_error) begin
                $error("stability_error expected %0b actual %0b",
                       want.stability_error, got.stability_error);
                fail_count++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_wr_data;

    stencil_scoreboard sb;
    bit                calm;          // no idling on either side while set
    int unsigned       rx_hold;
    int unsigned       rx_pick;
    int unsigned       stall_cycles;
    int                settings_seen;

    heat_equation_stencil_step_top #(
        .NODES(NODES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver pacing: mostly ready, short stalls often, long stalls rarely.
    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
            rx_hold <= 0;
        end else if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 70) begin
                m_ready <= 1'b1;
            end else if (rx_pick < 95) begin
                m_ready <= 1'b0;
                rx_hold <= $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b0;
                rx_hold <= $urandom_range(10, 40);
            end
        end
    end

    // Check result words first, then note the input word of the same edge;
    // a word accepted now can only owe results on later edges.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_input(s_data);
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) === 1'b1 || (m_valid && m_ready) === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_t make_word(logic mode, logic signed [VAL_W-1:0] lg,
                                      logic signed [VAL_W-1:0] rg,
                                      logic signed [VAL_W-1:0] lbv,
                                      logic use_l, logic use_r);
        in_t w;
        w.mode                = mode;
        w.left_ghost          = lg;
        w.right_ghost         = rg;
        w.left_boundary_value = lbv;
        w.use_left_boundary   = use_l;
        w.use_right_boundary  = use_r;
        return w;
    endfunction

    // Mix of extremes, full-range noise and temperatures near the grid's own.
    function automatic logic signed [VAL_W-1:0] rand_temp();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return Q_MAX;
        if (sel == 1) return Q_MIN;
        if (sel < 5) return $urandom;
        return int'($urandom_range(0, 13107200)) - 6553600;
    endfunction

    function automatic logic [VAL_W-1:0] rand_coef_data();
        int unsigned sel;
        logic [15:0] junk;
        junk = $urandom;
        sel  = $urandom_range(0, 11);
        if (sel == 0) return {junk, 16'd0};
        if (sel == 1) return {junk, 16'd32767};
        if (sel == 2) return {junk, 16'd65535};
        if (sel == 3) return {junk, 16'(COEF_HALF + $urandom_range(0, 32767))};
        return {junk, 16'($urandom_range(1, 32767))};
    endfunction

    function automatic in_t rand_word();
        logic mode;
        mode = ($urandom_range(0, 99) < 12) ? MODE_RESTART : MODE_STEP;
        return make_word(mode, rand_temp(), rand_temp(), rand_temp(),
                         $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    // Present one word, hold it until accepted, then idle a random gap.
    task automatic send_word(input in_t w);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every owed result word is back.
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers back to back; only called while idle.
    task automatic program_regs(input logic [VAL_W-1:0] coef_data,
                                input logic [VAL_W-1:0] init_data,
                                input logic [VAL_W-1:0] fixed_data,
                                input bit touch_spare);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_COEF;
        cfg_wr_data <= coef_data;
        @(posedge aclk);
        cfg_index   <= REG_INIT;
        cfg_wr_data <= init_data;
        @(posedge aclk);
        cfg_index   <= REG_FIXED;
        cfg_wr_data <= fixed_data;
        @(posedge aclk);
        if (touch_spare) begin
            cfg_index   <= REG_SPARE;
            cfg_wr_data <= $urandom;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        sb.write_reg(REG_COEF, coef_data);
        sb.write_reg(REG_INIT, init_data);
        sb.write_reg(REG_FIXED, fixed_data);
        settings_seen++;
    endtask

    initial begin
        sb            = new();
        calm          = 1'b0;
        rx_hold       = 0;
        stall_cycles  = 0;
        settings_seen = 1;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_COEF;
        cfg_wr_data   = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: coefficient 328, restart 95.0, fixed boundary 75.0.
        send_word(make_word(MODE_STEP, '0, '0, '0, 1'b0, 1'b0));
        send_word(make_word(MODE_STEP, Q_TEN, Q_TEN, Q_HUNDRED, 1'b1, 1'b1));
        send_word(make_word(MODE_STEP, Q_MAX, Q_MIN, Q_TEN, 1'b1, 1'b0));
        send_word(make_word(MODE_STEP, Q_MIN, Q_MAX, Q_MIN, 1'b0, 1'b1));
        send_word(make_word(MODE_RESTART, Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b1));
        wait_drain();

        // Largest stable coefficient with extreme register values; junk in the
        // unused upper coefficient bits, and a write to the undecoded index.
        program_regs({16'hFFFF, 16'd32767}, Q_MAX, Q_MIN, 1'b1);
        send_word(make_word(MODE_RESTART, '0, '0, '0, 1'b0, 1'b0));
        send_word(make_word(MODE_STEP, Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b1));
        send_word(make_word(MODE_STEP, Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b0));
        send_word(make_word(MODE_STEP, Q_MIN, Q_MAX, '0, 1'b0, 1'b0));
        wait_drain();

        // Exactly 0.5: steps refused and boundary inputs ignored; restart still works.
        program_regs({16'h0000, COEF_HALF}, '0, Q_HUNDRED, 1'b0);
        send_word(make_word(MODE_STEP, Q_MAX, Q_MIN, Q_TEN, 1'b1, 1'b1));
        send_word(make_word(MODE_RESTART, Q_MIN, Q_MAX, Q_MAX, 1'b1, 1'b1));
        send_word(make_word(MODE_STEP, Q_TEN, Q_TEN, Q_TEN, 1'b0, 1'b0));
        wait_drain();

        program_regs({16'h5A5A, 16'hFFFF}, Q_NEG_ONE, '0, 1'b0);
        send_word(make_word(MODE_STEP, Q_MIN, Q_MIN, Q_MAX, 1'b1, 1'b1));
        send_word(make_word(MODE_RESTART, '0, '0, '0, 1'b0, 1'b0));
        wait_drain();

        // Zero coefficient: only the boundary replacements move the nodes.
        program_regs('0, Q_MIN, Q_MAX, 1'b0);
        send_word(make_word(MODE_RESTART, '0, '0, '0, 1'b0, 1'b0));
        send_word(make_word(MODE_STEP, Q_MAX, Q_MAX, Q_NEG_ONE, 1'b1, 1'b1));
        send_word(make_word(MODE_STEP, '0, '0, '0, 1'b0, 1'b0));
        wait_drain();

        // Smallest coefficient on a zero grid: ghosts of plus and minus half an
        // LSB land exactly on rounding ties at the two ends.
        program_regs(32'd1, '0, FIXED_RESET, 1'b0);
        send_word(make_word(MODE_RESTART, '0, '0, '0, 1'b0, 1'b0));
        send_word(make_word(MODE_STEP, Q_HALF_LSB, -Q_HALF_LSB, '0, 1'b0, 1'b0));
        send_word(make_word(MODE_STEP, -Q_HALF_LSB - 1, Q_HALF_LSB - 1, '0, 1'b0, 1'b0));
        wait_drain();

        // Random phases: fresh register setting each, mostly steps.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            program_regs(rand_coef_data(),
                         (ph == 0) ? $urandom : rand_temp(),
                         rand_temp(), 1'b0);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % 8 == 0) calm = ($urandom_range(0, 3) == 0);
                // in phase 2, hold the sender off mid-phase until the grid has drained
                if (ph == 2 && n == WORDS_PER_PHASE / 2) wait_drain();
                send_word(rand_word());
            end
            wait_drain();
        end

        calm = 1'b0;
        repeat (8) @(posedge aclk);
        $display("covered %0d restarts, %0d applied steps, %0d refused steps over %0d settings",
                 sb.restarts, sb.steps_applied, sb.refusals, settings_seen);
        $display("checked %0d node result words, %0d mismatches",
                 sb.words_checked, sb.fail_count);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== heat_equation_stencil_step_top.f =====
+incdir+hw/rtl
hw/rtl/hes_pkg.sv
hw/rtl/hes_cell.sv
hw/rtl/heat_equation_stencil_step_top.sv
hw/rtl/hes_checker.sv
dv/tb_top.sv
